// File: hw/rtl/tstc_pkg.sv
// ----------------------------------------------------------------------------
// tstc_pkg
// Shared types, character codes and helpers for the timestamp text checker.
// ----------------------------------------------------------------------------
package tstc_pkg;

    // Field the matcher is currently working on
    typedef enum logic [2:0] {
        ST_YEAR   = 3'd0,
        ST_MONTH  = 3'd1,
        ST_DAY    = 3'd2,
        ST_HOUR   = 3'd3,
        ST_MINUTE = 3'd4,
        ST_SECOND = 3'd5,
        ST_TRAIL  = 3'd6
    } stage_t;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VTAB  = 8'h0b;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Digit counts that end a field
    localparam logic [2:0] YEAR_DIGITS  = 3'd4;
    localparam logic [2:0] SHORT_DIGITS = 3'd2;

    // Verdict carried with each result beat
    typedef struct packed {
        logic complete;
        logic ok_so_far;
    } match_res_t;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Whitespace allowed in the year field, before its fourth digit
    function automatic logic is_lead_ws(input logic [7:0] c);
        is_lead_ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB);
    endfunction

    // Whitespace allowed after the seconds
    function automatic logic is_trail_ws(input logic [7:0] c);
        is_trail_ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                      (c == CH_VTAB) || (c == CH_CR);
    endfunction

endpackage

// File: hw/rtl/tstc_matcher.sv
// ----------------------------------------------------------------------------
// tstc_matcher
// Pattern state and the single-byte next-state logic of the checker.
// ----------------------------------------------------------------------------
module tstc_matcher (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,   // one byte moves to the result stage
    input  logic [7:0]            ch,
    input  logic                  first,
    output tstc_pkg::match_res_t  res        // verdict after this byte
);

    tstc_pkg::stage_t stage_reg, stage_next;
    logic [2:0]       digits_reg, digits_next;
    logic             valid_reg, valid_next;

    tstc_pkg::stage_t cur_stage, new_stage;
    logic [2:0]       cur_digits, new_digits;
    logic             cur_valid;
    logic             hit;
    logic             dig;
    logic [7:0]       sep;
    logic [2:0]       digits_inc;

    // First byte of a subject starts from the reset state
    always_comb begin
        cur_stage  = first ? tstc_pkg::ST_YEAR : stage_reg;
        cur_digits = first ? 3'd0 : digits_reg;
        cur_valid  = first ? 1'b1 : valid_reg;
    end

    // Separator that closes each short field
    always_comb begin
        case (cur_stage)
            tstc_pkg::ST_MONTH:  sep = tstc_pkg::CH_DASH;
            tstc_pkg::ST_DAY:    sep = tstc_pkg::CH_SPACE;
            tstc_pkg::ST_HOUR:   sep = tstc_pkg::CH_COLON;
            tstc_pkg::ST_MINUTE: sep = tstc_pkg::CH_COLON;
            default:             sep = tstc_pkg::CH_COLON;
        endcase
    end

    // Match one byte
    always_comb begin
        dig        = tstc_pkg::is_digit(ch);
        digits_inc = cur_digits + 3'd1;
        new_stage  = cur_stage;
        new_digits = cur_digits;
        hit        = 1'b0;
        case (cur_stage)
            tstc_pkg::ST_YEAR: begin
                if (cur_digits < tstc_pkg::YEAR_DIGITS) begin
                    if (tstc_pkg::is_lead_ws(ch)) begin
                        hit = 1'b1;
                    end else if (dig) begin
                        hit        = 1'b1;
                        new_digits = digits_inc;
                    end
                end else if (ch == tstc_pkg::CH_DASH) begin
                    hit        = 1'b1;
                    new_stage  = tstc_pkg::ST_MONTH;
                    new_digits = 3'd0;
                end
            end
            tstc_pkg::ST_MONTH, tstc_pkg::ST_DAY,
            tstc_pkg::ST_HOUR, tstc_pkg::ST_MINUTE: begin
                if (cur_digits != 3'd0 && ch == sep) begin
                    hit        = 1'b1;
                    new_stage  = tstc_pkg::stage_t'(cur_stage + 3'd1);
                    new_digits = 3'd0;
                end else if (cur_digits < tstc_pkg::SHORT_DIGITS && dig) begin
                    hit        = 1'b1;
                    new_digits = digits_inc;
                end
            end
            tstc_pkg::ST_SECOND: begin
                if (dig) begin
                    hit = 1'b1;
                    if (digits_inc >= tstc_pkg::SHORT_DIGITS) begin
                        new_stage  = tstc_pkg::ST_TRAIL;
                        new_digits = 3'd0;
                    end else begin
                        new_digits = digits_inc;
                    end
                end
            end
            tstc_pkg::ST_TRAIL: begin
                hit = tstc_pkg::is_trail_ws(ch);
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    // State freezes once the subject has failed
    always_comb begin
        stage_next    = cur_stage;
        digits_next   = cur_digits;
        valid_next    = cur_valid;
        if (cur_valid) begin
            if (hit) begin
                stage_next  = new_stage;
                digits_next = new_digits;
            end else begin
                valid_next  = 1'b0;
            end
        end
        res.ok_so_far = valid_next;
        res.complete  = (stage_next == tstc_pkg::ST_TRAIL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg  <= tstc_pkg::ST_YEAR;
            digits_reg <= 3'd0;
            valid_reg  <= 1'b1;
        end else if (step_en) begin
            stage_reg  <= stage_next;
            digits_reg <= digits_next;
            valid_reg  <= valid_next;
        end
    end

endmodule

// File: hw/rtl/tstc_out_reg.sv
// ----------------------------------------------------------------------------
// tstc_out_reg
// Result register holding one verdict beat for the downstream side.
// ----------------------------------------------------------------------------
module tstc_out_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,      // new verdict enters
    input  tstc_pkg::match_res_t  res,
    input  logic                  last_in,
    output logic                  ready,     // register can take a verdict
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] ok_so_far, [1] complete, [7:2] zero
    output logic                  m_tlast    // end_flag
);

    logic                 valid_reg;
    tstc_pkg::match_res_t res_reg;
    logic                 last_reg;

    assign ready = !valid_reg || m_tready;

    // Valid flag: set on load, cleared when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= load;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load && ready) begin
            res_reg  <= res;
            last_reg <= last_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, res_reg.complete, res_reg.ok_so_far};
    assign m_tlast  = last_reg;

endmodule

// File: hw/rtl/timestamp_text_checker_unit.sv
// ----------------------------------------------------------------------------
// timestamp_text_checker_unit
// Byte-serial checker for "YYYY-M-D h:m:ss" style timestamp text.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one text byte per beat: s_tdata is the byte, s_tuser
//   marks the first byte of a new subject (matcher restarts before it is
//   checked), s_tlast marks the last byte of the subject.
//   Master side gives one verdict beat per input beat, in order:
//   m_tdata[0] ok_so_far, m_tdata[1] complete, m_tlast copies s_tlast.
//   The verdict for a subject is read on the beat with m_tlast set; a good
//   timestamp shows both ok_so_far and complete there.
//   Each input beat passes the input register, then the result register.
//   Throughput: one byte per cycle unless the result side stalls; the stage
//   and digit count update in one short compare path between the registers.
//   Reset (aresetn low, synchronous) empties both registers and returns
//   the matcher to the start of the year field.
//   When m_tready is low the result register holds; the input register
//   still fills once, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module timestamp_text_checker_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] ch
    input  logic       s_tuser,    // first
    input  logic       s_tlast,    // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [0] ok_so_far, [1] complete, [7:2] zero
    output logic       m_tlast     // end_flag
);

    logic                 in_valid_reg;
    logic [7:0]           ch_reg;
    logic                 first_reg;
    logic                 last_reg;
    logic                 out_ready;
    logic                 step;
    tstc_pkg::match_res_t res;

    assign step     = in_valid_reg && out_ready;
    assign s_tready = !in_valid_reg || out_ready;

    // Input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg    <= s_tdata;
            first_reg <= s_tuser;
            last_reg  <= s_tlast;
        end
    end

    tstc_matcher u_matcher (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step),
        .ch      (ch_reg),
        .first   (first_reg),
        .res     (res)
    );

    tstc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (in_valid_reg),
        .res      (res),
        .last_in  (last_reg),
        .ready    (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: hw/rtl/tstc_checker.sv
// ----------------------------------------------------------------------------
// tstc_checker
// Port-level checks for the timestamp text checker, bound to the top level.
// ----------------------------------------------------------------------------
module tstc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled result beat stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // Reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Pad bits of the result stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:2] == 6'd0))
        else $error("result pad bits set");

    // No input beat is taken while both stages are full and stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && $past(m_tvalid && !m_tready) &&
        $past(s_tvalid && s_tready) |-> !s_tready)
        else $error("input taken with both stages full");

endmodule

bind timestamp_text_checker_unit tstc_checker u_tstc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
